// File: design/thfd_pkg.sv
package thfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
    logic        temp_ok;
    logic        hum_ok;
  } frame_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: design/thfd_front.sv
module thfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  input  logic                frame_start,
  output logic                frame_push,
  output thfd_pkg::frame_t    frame
);
  import thfd_pkg::*;

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] raw_temperature, raw_temperature_next;
  logic [15:0] raw_humidity, raw_humidity_next;
  logic        temp_check, temp_check_next;
  logic [2:0]  pos;

  always_comb begin
    pos = byte_position;
    if (frame_start || byte_position > POS_H_CRC) begin
      pos = POS_T_HI;
    end
    byte_position_next   = byte_position;
    running_crc_next     = running_crc;
    raw_temperature_next = raw_temperature;
    raw_humidity_next    = raw_humidity;
    temp_check_next      = temp_check;
    frame_push           = 1'b0;
    frame.raw_temp       = raw_temperature;
    frame.raw_hum        = raw_humidity;
    frame.temp_ok        = temp_check;
    frame.hum_ok         = (byte_in == running_crc);
    if (accept) begin
      byte_position_next = pos + 3'd1;
      case (pos)
        POS_T_HI: begin
          running_crc_next     = crc8_step(CRC_INIT, byte_in);
          raw_temperature_next = {byte_in, 8'h00};
        end
        POS_T_LO: begin
          running_crc_next     = crc8_step(running_crc, byte_in);
          raw_temperature_next = {raw_temperature[15:8], byte_in};
        end
        POS_T_CRC: begin
          temp_check_next  = (byte_in == running_crc);
          running_crc_next = CRC_INIT;
        end
        POS_H_HI: begin
          running_crc_next  = crc8_step(CRC_INIT, byte_in);
          raw_humidity_next = {byte_in, 8'h00};
        end
        POS_H_LO: begin
          running_crc_next  = crc8_step(running_crc, byte_in);
          raw_humidity_next = {raw_humidity[15:8], byte_in};
        end
        default: begin
          running_crc_next   = CRC_INIT;
          byte_position_next = POS_T_HI;
          frame_push         = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_T_HI;
      running_crc     <= CRC_INIT;
      raw_temperature <= '0;
      raw_humidity    <= '0;
      temp_check      <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      running_crc     <= running_crc_next;
      raw_temperature <= raw_temperature_next;
      raw_humidity    <= raw_humidity_next;
      temp_check      <= temp_check_next;
    end
  end

endmodule

// File: design/thfd_queue.sv
module thfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  thfd_pkg::frame_t wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output thfd_pkg::frame_t rd_data,
  output logic             q_valid
);
  import thfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/thfd_back.sv
module thfd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  thfd_pkg::frame_t   frame,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic               temp_crc_ok,
  output logic               hum_crc_ok
);
  import thfd_pkg::*;

  logic        s1_valid;
  logic [30:0] prod_temp;
  logic [29:0] prod_hum;
  logic        s1_temp_ok;
  logic        s1_hum_ok;
  logic        s2_valid;
  logic        s1_ready;
  logic        s2_ready;
  logic [31:0] sum_temp;
  logic [30:0] sum_hum;
  logic [15:0] quo_temp;
  logic [14:0] quo_hum;
  logic [15:0] temp_val;

  assign s2_ready = !s2_valid || pop;
  assign s1_ready = !s1_valid || s2_ready;
  assign q_pop    = q_valid && s1_ready;
  assign empty    = !s2_valid;

  // floor(x / 65535) for quotients below 2^16
  assign sum_temp = 32'(prod_temp) + 32'(prod_temp[30:16]) + 32'd1;
  assign sum_hum  = 31'(prod_hum) + 31'(prod_hum[29:16]) + 31'd1;
  assign quo_temp = sum_temp[31:16];
  assign quo_hum  = sum_hum[30:16];
  assign temp_val = quo_temp - TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_temp  <= 31'(frame.raw_temp) * 31'(TEMP_SCALE);
      prod_hum   <= 30'(frame.raw_hum) * 30'(HUM_SCALE);
      s1_temp_ok <= frame.temp_ok;
      s1_hum_ok  <= frame.hum_ok;
    end
    if (s1_valid && s2_ready) begin
      temp_crc_ok <= s1_temp_ok;
      hum_crc_ok  <= s1_hum_ok;
      if (s1_temp_ok && s1_hum_ok) begin
        temperature_centi <= temp_val[14:0];
        humidity_centi    <= quo_hum[13:0];
      end else begin
        temperature_centi <= '0;
        humidity_centi    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

endmodule

// File: design/temp_humidity_frame_decoder.sv
// Temperature/humidity reply decoder.
// Input side is a queue write port: push with byte_in/frame_start, held off by full.
// Bytes arrive in reply order: temp hi, temp lo, temp CRC, hum hi, hum lo, hum CRC.
// frame_start marks a byte as the first of a reply and drops any partial reply.
// After the sixth byte one result word is queued; empty low shows it, pop takes it.
// Throughput: one byte per cycle unless full; one word per cycle drained by pop.
// The frame is queued at the edge that takes the sixth byte, then read from the
// frame queue into the multiply stage, then into the scale/output register.
// Results: centi-degrees C and centi-percent RH, both zero if either CRC failed;
// temp_crc_ok and hum_crc_ok tell which check failed.
// When pop stays low the output word holds, the two-stage back end and the
// QUEUE_DEPTH frame queue fill, and full rises only once the frame queue is full.
// Synchronous reset empties all stages and restarts at the first byte position.
module temp_humidity_frame_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         byte_in,
  input  logic               frame_start,
  output logic               empty,
  input  logic               pop,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic               temp_crc_ok,
  output logic               hum_crc_ok
);
  import thfd_pkg::*;

  logic   accept;
  logic   frame_push;
  frame_t frame_in;
  frame_t frame_out;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  thfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_in    (byte_in),
    .frame_start(frame_start),
    .frame_push (frame_push),
    .frame      (frame_in)
  );

  thfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (frame_push),
    .wr_data(frame_in),
    .q_full (q_full),
    .rd_en  (q_pop),
    .rd_data(frame_out),
    .q_valid(q_valid)
  );

  thfd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .frame            (frame_out),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .temperature_centi(temperature_centi),
    .humidity_centi   (humidity_centi),
    .temp_crc_ok      (temp_crc_ok),
    .hum_crc_ok       (hum_crc_ok)
  );

endmodule

// File: design/thfd_checker.sv
module thfd_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic signed [14:0] temperature_centi,
  input logic [13:0]        humidity_centi,
  input logic               temp_crc_ok,
  input logic               hum_crc_ok
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result word present after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !(temp_crc_ok && hum_crc_ok)) |->
      (temperature_centi == 15'sd0 && humidity_centi == 14'd0))
    else $error("nonzero values on CRC failure");

  a_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && temp_crc_ok && hum_crc_ok) |->
      (humidity_centi <= 14'd10000 && temperature_centi >= -15'sd4500 &&
       temperature_centi <= 15'sd13000))
    else $error("result out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=>
      (!empty && $stable(temperature_centi) && $stable(humidity_centi) &&
       $stable(temp_crc_ok) && $stable(hum_crc_ok)))
    else $error("stalled result word changed");

endmodule

bind temp_humidity_frame_decoder thfd_checker u_thfd_checker (.*);
